// ----- src/ftle_pkg.sv -----
// shared types, constants and float helpers for the tolerance equality core
`default_nettype none
package ftle_pkg;

	localparam int SUB_STG  = 4;
	localparam int DIV_ITER = 27;
	localparam int DIV_STG  = DIV_ITER + 3;
	localparam int PIPE_STG = SUB_STG + DIV_STG + 1;

	localparam logic [1:0] MODE_ABS  = 2'd0;
	localparam logic [1:0] MODE_REL  = 2'd1;
	localparam logic [1:0] MODE_DIST = 2'd2;

	localparam logic REG_MODE = 1'b0;
	localparam logic REG_TOL  = 1'b1;

	localparam logic [30:0] MAG_QNAN = 31'h7FC00000;
	localparam logic [30:0] MAG_INF  = 31'h7F800000;
	localparam logic [31:0] SIGN_MASK = 32'h80000000;

	typedef struct packed {
		logic [1:0]  mode;
		logic        eq;
		logic        dist_ok;
		logic        abs_ok;
		logic        den_zero;
		logic [30:0] den;
	} side_t;

	function automatic logic f_is_nan(input logic [30:0] m);
		return (m[30:23] == 8'hFF) && (m[22:0] != 23'd0);
	endfunction

	function automatic logic f_is_inf(input logic [30:0] m);
		return (m[30:23] == 8'hFF) && (m[22:0] == 23'd0);
	endfunction

	function automatic logic [4:0] f_lzc27(input logic [26:0] v);
		logic [4:0] c;
		c = 5'd27;
		for (int i = 0; i < 27; i++) begin
			if (v[i]) c = 5'(26 - i);
		end
		return c;
	endfunction

	function automatic logic [4:0] f_lzc24(input logic [23:0] v);
		logic [4:0] c;
		c = 5'd24;
		for (int i = 0; i < 24; i++) begin
			if (v[i]) c = 5'(23 - i);
		end
		return c;
	endfunction

	// nonnegative magnitude x against a full float tolerance, ieee <=
	function automatic logic f_le_tol(input logic [30:0] x, input logic [31:0] tol);
		logic r;
		if (f_is_nan(x) || f_is_nan(tol[30:0])) r = 1'b0;
		else if ((tol & SIGN_MASK) != 32'd0) r = (x == 31'd0) && (tol[30:0] == 31'd0);
		else r = (x <= tol[30:0]);
		return r;
	endfunction

	// tolerance truncated to an unsigned count, saturating
	function automatic logic [31:0] f_tol_count(input logic [31:0] t);
		logic [7:0]  e;
		logic [23:0] m;
		logic [31:0] r;
		e = t[30:23];
		m = {1'b1, t[22:0]};
		if (t[31] || f_is_nan(t[30:0]) || (t[30:0] == 31'd0)) r = 32'd0;
		else if (e >= 8'd159) r = 32'hFFFFFFFF;
		else if (e < 8'd127) r = 32'd0;
		else if (e >= 8'd150) r = {8'd0, m} << (e - 8'd150);
		else r = {8'd0, m} >> (8'd150 - e);
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- src/ftle_addsub.sv -----
// four stage magnitude of a float difference, round to nearest even
`default_nettype none
module ftle_addsub import ftle_pkg::*; (
	input  wire logic                 clk,
	input  wire logic [SUB_STG-1:0]   ld,
	input  wire logic [31:0]          a,
	input  wire logic [31:0]          b,
	output logic      [30:0]          diff
);

	logic [23:0] mx_s1, my_s1;
	logic [7:0]  ex_s1;
	logic [4:0]  d_s1;
	logic        sub_s1, nan_s1, inf_s1;

	logic [26:0] xm_s2, yal_s2;
	logic [7:0]  ex_s2;
	logic        sub_s2, nan_s2, inf_s2;

	logic [27:0] r_s3;
	logic [4:0]  lz_s3;
	logic [7:0]  ex_s3;
	logic        nan_s3, inf_s3;

	logic [30:0] diff_s4;

	// swap so that x holds the larger magnitude
	logic [30:0] x_c, y_c;
	logic [7:0]  xe_eff, ye_eff, d_c;
	logic        sub_c;
	always_comb begin
		sub_c = (a[31] == b[31]);
		if (b[30:0] > a[30:0]) begin
			x_c = b[30:0];
			y_c = a[30:0];
		end else begin
			x_c = a[30:0];
			y_c = b[30:0];
		end
		xe_eff = (x_c[30:23] == 8'd0) ? 8'd1 : x_c[30:23];
		ye_eff = (y_c[30:23] == 8'd0) ? 8'd1 : y_c[30:23];
		d_c = xe_eff - ye_eff;
	end

	always_ff @(posedge clk) begin
		if (ld[0]) begin
			mx_s1  <= {x_c[30:23] != 8'd0, x_c[22:0]};
			my_s1  <= {y_c[30:23] != 8'd0, y_c[22:0]};
			ex_s1  <= xe_eff;
			d_s1   <= (d_c > 8'd27) ? 5'd27 : d_c[4:0];
			sub_s1 <= sub_c;
			nan_s1 <= f_is_nan(x_c) || f_is_nan(y_c)
				|| (f_is_inf(x_c) && f_is_inf(y_c) && sub_c);
			inf_s1 <= f_is_inf(x_c);
		end
	end

	// align the smaller operand, shifted out bits fold into sticky
	logic [26:0] ext_c, sh_c;
	logic        lost_c;
	always_comb begin
		ext_c  = {my_s1, 3'b000};
		sh_c   = ext_c >> d_s1;
		lost_c = |(ext_c & ~({27{1'b1}} << d_s1));
	end

	always_ff @(posedge clk) begin
		if (ld[1]) begin
			xm_s2  <= {mx_s1, 3'b000};
			yal_s2 <= {sh_c[26:1], sh_c[0] | lost_c};
			ex_s2  <= ex_s1;
			sub_s2 <= sub_s1;
			nan_s2 <= nan_s1;
			inf_s2 <= inf_s1;
		end
	end

	logic [27:0] r_c;
	always_comb begin
		if (sub_s2) r_c = {1'b0, xm_s2} - {1'b0, yal_s2};
		else r_c = {1'b0, xm_s2} + {1'b0, yal_s2};
	end

	always_ff @(posedge clk) begin
		if (ld[2]) begin
			r_s3   <= r_c;
			lz_s3  <= f_lzc27(r_c[26:0]);
			ex_s3  <= ex_s2;
			nan_s3 <= nan_s2;
			inf_s3 <= inf_s2;
		end
	end

	// normalize, round and pack
	logic [7:0]  elim_c;
	logic [4:0]  s_c;
	logic [26:0] n_c;
	logic [8:0]  e_c, enc_c;
	logic        up_c;
	logic [31:0] pk_c;
	logic [30:0] res_c;
	always_comb begin
		elim_c = ex_s3 - 8'd1;
		s_c = ({3'b000, lz_s3} > elim_c) ? elim_c[4:0] : lz_s3;
		if (r_s3[27]) begin
			n_c = {r_s3[27:2], r_s3[1] | r_s3[0]};
			e_c = {1'b0, ex_s3} + 9'd1;
		end else begin
			n_c = r_s3[26:0] << s_c;
			e_c = {1'b0, ex_s3} - {4'd0, s_c};
		end
		enc_c = n_c[26] ? (e_c - 9'd1) : 9'd0;
		up_c = n_c[2] & (n_c[1] | n_c[0] | n_c[3]);
		pk_c = {enc_c, 23'd0} + {8'd0, n_c[26:3]} + {31'd0, up_c};
		if (nan_s3) res_c = MAG_QNAN;
		else if (inf_s3 || (pk_c[31:23] >= 9'd255)) res_c = MAG_INF;
		else res_c = pk_c[30:0];
	end

	always_ff @(posedge clk) begin
		if (ld[3]) begin
			diff_s4 <= res_c;
		end
	end

	assign diff = diff_s4;

endmodule
`default_nettype wire

// ----- src/ftle_div.sv -----
// pipelined restoring divider of two float magnitudes, one quotient bit per stage
`default_nettype none
module ftle_div import ftle_pkg::*; (
	input  wire logic                 clk,
	input  wire logic [DIV_STG-1:0]   ld,
	input  wire logic [30:0]          x,
	input  wire logic [30:0]          y,
	output logic      [30:0]          q
);

	typedef struct packed {
		logic [24:0] rem;
		logic [23:0] mb;
		logic [26:0] qb;
		logic [10:0] e;
		logic        nan;
		logic        inf;
		logic        zero;
	} div_it_t;

	typedef struct packed {
		logic [25:0] v;
		logic [7:0]  enc;
		logic        ovf;
		logic        nan;
		logic        inf;
		logic        zero;
	} div_rnd_t;

	div_it_t  it_s [0:DIV_ITER];
	div_rnd_t dn_s;
	logic [30:0] q_s;

	function automatic div_it_t f_step(input div_it_t p);
		div_it_t     n;
		logic        bit_q;
		logic [24:0] r;
		n = p;
		bit_q = (p.rem >= {1'b0, p.mb});
		r = bit_q ? (p.rem - {1'b0, p.mb}) : p.rem;
		n.rem = {r[23:0], 1'b0};
		n.qb = {p.qb[25:0], bit_q};
		return n;
	endfunction

	// operand prep: specials and normalized mantissas
	logic [7:0]  xe_eff, ye_eff;
	logic [23:0] mxr_c, myr_c;
	logic [4:0]  lzx_c, lzy_c;
	div_it_t     p_c;
	always_comb begin
		xe_eff = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
		ye_eff = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
		mxr_c = {x[30:23] != 8'd0, x[22:0]};
		myr_c = {y[30:23] != 8'd0, y[22:0]};
		lzx_c = f_lzc24(mxr_c);
		lzy_c = f_lzc24(myr_c);
		p_c.rem = {1'b0, mxr_c << lzx_c};
		p_c.mb = myr_c << lzy_c;
		p_c.qb = 27'd0;
		p_c.e = {3'd0, xe_eff} - {6'd0, lzx_c} - {3'd0, ye_eff} + {6'd0, lzy_c} + 11'd127;
		p_c.nan = f_is_nan(x) || f_is_nan(y) || (f_is_inf(x) && f_is_inf(y))
			|| ((x == 31'd0) && (y == 31'd0));
		p_c.inf = f_is_inf(x) || (y == 31'd0);
		p_c.zero = (x == 31'd0) || f_is_inf(y);
	end

	always_ff @(posedge clk) begin
		if (ld[0]) begin
			it_s[0] <= p_c;
		end
	end

	for (genvar j = 1; j <= DIV_ITER; j++) begin : g_iter
		always_ff @(posedge clk) begin
			if (ld[j]) begin
				it_s[j] <= f_step(it_s[j-1]);
			end
		end
	end

	// pick the leading bit, shift into subnormal range with sticky
	div_it_t      t_c;
	logic [23:0]  m_c;
	logic         g_c, st_c;
	logic [10:0]  e2_c, nd_c;
	logic [4:0]   sh_c;
	logic [25:0]  v_c, vs_c;
	logic         lost_c, subn_c;
	div_rnd_t     d_c;
	always_comb begin
		t_c = it_s[DIV_ITER];
		if (t_c.qb[26]) begin
			m_c = t_c.qb[26:3];
			g_c = t_c.qb[2];
			st_c = (|t_c.qb[1:0]) | (t_c.rem != 25'd0);
			e2_c = t_c.e;
		end else begin
			m_c = t_c.qb[25:2];
			g_c = t_c.qb[1];
			st_c = t_c.qb[0] | (t_c.rem != 25'd0);
			e2_c = t_c.e - 11'd1;
		end
		subn_c = ($signed(e2_c) < 11'sd1);
		nd_c = 11'd1 - e2_c;
		sh_c = subn_c ? ((nd_c > 11'd26) ? 5'd26 : nd_c[4:0]) : 5'd0;
		v_c = {m_c, g_c, st_c};
		vs_c = v_c >> sh_c;
		lost_c = |(v_c & ~({26{1'b1}} << sh_c));
		d_c.v = {vs_c[25:1], vs_c[0] | lost_c};
		d_c.enc = subn_c ? 8'd0 : 8'(e2_c - 11'd1);
		d_c.ovf = ($signed(e2_c) >= 11'sd255);
		d_c.nan = t_c.nan;
		d_c.inf = t_c.inf;
		d_c.zero = t_c.zero;
	end

	always_ff @(posedge clk) begin
		if (ld[DIV_ITER+1]) begin
			dn_s <= d_c;
		end
	end

	logic        up_c;
	logic [31:0] pk_c;
	logic [30:0] res_c;
	always_comb begin
		up_c = dn_s.v[1] & (dn_s.v[0] | dn_s.v[2]);
		pk_c = {1'b0, dn_s.enc, 23'd0} + {8'd0, dn_s.v[25:2]} + {31'd0, up_c};
		if (dn_s.nan) res_c = MAG_QNAN;
		else if (dn_s.inf || dn_s.ovf || (pk_c[31:23] >= 9'd255)) res_c = MAG_INF;
		else if (dn_s.zero) res_c = 31'd0;
		else res_c = pk_c[30:0];
	end

	always_ff @(posedge clk) begin
		if (ld[DIV_ITER+2]) begin
			q_s <= res_c;
		end
	end

	assign q = q_s;

endmodule
`default_nettype wire

// ----- src/float_tolerance_equality_core.sv -----
// top level: float tolerance equality with absolute, relative and distance tests
// results come from a register behind the last stage; one item per cycle sustained while out_stall is low
// the divider sets the depth: 27 quotient bit stages plus prep and rounding
// a stalled result holds only the stages behind it that are full; bubbles close up
// reset clears every valid bit and sets mode_q, tol_q and tcnt_q to 0
`default_nettype none
module float_tolerance_equality_core import ftle_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] first_value,
	input  wire logic [31:0] second_value,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             is_close,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_data
);

	logic [1:0]  mode_q;
	logic [31:0] tol_q;
	logic [31:0] tcnt_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_ABS;
			tol_q  <= 32'd0;
			tcnt_q <= 32'd0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MODE: mode_q <= cfg_data[1:0];
				REG_TOL: begin
					tol_q  <= cfg_data;
					tcnt_q <= f_tol_count(cfg_data);
				end
				default: ;
			endcase
		end
	end

	// stage k loads when it is empty or everything ahead of it can move
	logic [PIPE_STG-1:0] vld_q;
	logic [PIPE_STG-1:0] ld;
	always_comb begin
		for (int k = 0; k < PIPE_STG; k++) begin
			ld[k] = !out_stall || (|(~vld_q & ({PIPE_STG{1'b1}} << k)));
		end
	end

	assign in_stall = !ld[0];
	assign out_valid = vld_q[PIPE_STG-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (ld[0]) vld_q[0] <= in_valid;
			for (int k = 1; k < PIPE_STG; k++) begin
				if (ld[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	// entry: exact equality, max magnitude, ordered image difference
	logic        nan_a, nan_b, eq_c;
	logic [33:0] ia_c, ib_c;
	side_t       side0_c;
	always_comb begin
		nan_a = f_is_nan(first_value[30:0]);
		nan_b = f_is_nan(second_value[30:0]);
		eq_c = !nan_a && !nan_b && ((first_value == second_value)
			|| ((first_value[30:0] == 31'd0) && (second_value[30:0] == 31'd0)));
		ia_c = first_value[31] ? (34'd0 - {3'd0, first_value[30:0]})
			: {3'd0, first_value[30:0]};
		ib_c = second_value[31] ? (34'd0 - {3'd0, second_value[30:0]})
			: {3'd0, second_value[30:0]};
		side0_c.mode = mode_q;
		side0_c.eq = eq_c;
		side0_c.dist_ok = 1'b0;
		side0_c.abs_ok = 1'b0;
		side0_c.den = (first_value[30:0] > second_value[30:0]) ? first_value[30:0]
			: second_value[30:0];
		side0_c.den_zero = (first_value[30:0] == 31'd0) && (second_value[30:0] == 31'd0);
	end

	side_t       side_s [0:PIPE_STG-2];
	logic [33:0] dimg_s1;
	logic        ninf_s1;

	always_ff @(posedge clk) begin
		if (ld[0]) begin
			side_s[0] <= side0_c;
			dimg_s1 <= ia_c - ib_c;
			ninf_s1 <= (first_value[30:23] == 8'hFF) || (second_value[30:23] == 8'hFF);
		end
	end

	logic [33:0] absd_c;
	assign absd_c = dimg_s1[33] ? (34'd0 - dimg_s1) : dimg_s1;

	logic [30:0] diff;
	logic [30:0] quot;

	for (genvar k = 1; k <= PIPE_STG - 2; k++) begin : g_side
		always_ff @(posedge clk) begin
			side_t nx;
			nx = side_s[k-1];
			if (k == 1) nx.dist_ok = !ninf_s1 && (absd_c <= {2'd0, tcnt_q});
			if (k == SUB_STG) nx.abs_ok = f_le_tol(diff, tol_q);
			if (ld[k]) begin
				side_s[k] <= nx;
			end
		end
	end

	ftle_addsub u_addsub (
		.clk  (clk),
		.ld   (ld[SUB_STG-1:0]),
		.a    (first_value),
		.b    (second_value),
		.diff (diff)
	);

	ftle_div u_div (
		.clk (clk),
		.ld  (ld[SUB_STG +: DIV_STG]),
		.x   (diff),
		.y   (side_s[SUB_STG-1].den),
		.q   (quot)
	);

	side_t sl_c;
	logic  close_c;
	always_comb begin
		sl_c = side_s[PIPE_STG-2];
		close_c = sl_c.eq
			|| ((sl_c.mode == MODE_ABS) && sl_c.abs_ok)
			|| ((sl_c.mode == MODE_REL) && !sl_c.den_zero && f_le_tol(quot, tol_q))
			|| ((sl_c.mode == MODE_DIST) && sl_c.dist_ok);
	end

	logic close_s;
	always_ff @(posedge clk) begin
		if (ld[PIPE_STG-1]) begin
			close_s <= close_c;
		end
	end

	assign is_close = close_s;

endmodule
`default_nettype wire
